// ===== design/gbi_pkg.sv =====
package gbi_pkg;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_RANGE  = 2'd1;
    localparam logic [1:0] STATUS_LOADED = 2'd2;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_RANGE = 2'd1,
        KIND_QUERY = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [16:0] ip0;
        logic [16:0] ip1;
        logic [16:0] jp0;
        logic [16:0] jp1;
        logic        do_y;
        logic [15:0] value;
    } entry_t;

    typedef struct packed {
        kind_t       kind;
        logic [16:0] w;
        logic [16:0] jw;
        logic        t_end;
        logic        y_first;
        logic        y_last;
    } op_t;

    // |p| clamped to 1.0 in Q16
    function automatic logic [16:0] gbi_weight(input logic signed [29:0] p);
        logic [29:0] mag;
        mag = p[29] ? 30'(-p) : 30'(p);
        return (mag > 30'(ONE_Q16)) ? ONE_Q16 : mag[16:0];
    endfunction

endpackage

// ===== design/gbi_front.sv =====
module gbi_front #(
    parameter int GRID_COLS = 360,
    parameter int GRID_ROWS = 180,
    localparam int CW = $clog2(GRID_COLS),
    localparam int RW = $clog2(GRID_ROWS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic                action,
    input  logic signed [10:0]  grid_col,
    input  logic signed [10:0]  grid_row,
    input  logic signed [15:0]  cell_value,
    input  logic signed [23:0]  latitude,
    input  logic        [24:0]  longitude,
    output logic                push_valid,
    input  logic                push_full,
    output gbi_pkg::entry_t     entry,
    output logic [CW-1:0]       col,
    output logic [RW-1:0]       row,
    output logic [CW-1:0]       col_nb,
    output logic [RW-1:0]       row_nb
);
    import gbi_pkg::*;

    localparam logic signed [13:0] ROW_BIAS = 14'(2 * (GRID_ROWS / 2));
    localparam logic signed [29:0] WRAP     = 30'(GRID_COLS * 65536);
    localparam logic signed [29:0] ONE_S    = 30'sd65536;
    localparam logic signed [29:0] ROW_K    = 30'((GRID_ROWS / 2) * 65536 - 32768);

    logic                a_valid_reg, a_valid_next;
    logic                a_action_reg;
    logic                a_oor_reg;
    logic [CW-1:0]       a_col_reg;
    logic [RW-1:0]       a_row_reg;
    logic [15:0]         a_value_reg;
    logic signed [23:0]  a_lat_reg;
    logic [24:0]         a_lon_reg;
    logic                a_right_reg;
    logic                a_up_reg;

    logic                accept;
    logic                oor;
    logic                right;
    logic                up;
    logic signed [13:0]  lat_hi;
    logic signed [13:0]  up_lim;
    logic                do_y;
    logic signed [29:0]  p_col;
    logic signed [29:0]  p_wrap;
    logic signed [29:0]  q_row;
    logic [16:0]         ip0;
    logic [16:0]         jp0;

    assign item_stall = a_valid_reg && push_full;
    assign accept     = item_valid && !item_stall;

    assign oor = grid_col[10] || grid_row[10]
              || ({2'b00, grid_col[9:0]} > 12'(GRID_COLS - 1))
              || ({1'b0, grid_row[9:0]} > 11'(GRID_ROWS - 1));

    assign right  = {1'b0, longitude[24:15]} >= {grid_col[9:0], 1'b1};
    assign lat_hi = {{5{latitude[23]}}, latitude[23:15]};
    assign up_lim = $signed({3'b000, grid_row[9:0], 1'b1}) - ROW_BIAS;
    assign up     = lat_hi >= up_lim;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (!item_stall)
        begin
            a_valid_next = item_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_action_reg <= action;
            a_oor_reg    <= oor;
            a_col_reg    <= CW'(grid_col[9:0]);
            a_row_reg    <= RW'(grid_row[9:0]);
            a_value_reg  <= cell_value;
            a_lat_reg    <= latitude;
            a_lon_reg    <= longitude;
            a_right_reg  <= right;
            a_up_reg     <= up;
        end
    end

    always_comb
    begin
        if (a_right_reg)
        begin
            col_nb = (a_col_reg == CW'(GRID_COLS - 1)) ? '0 : a_col_reg + 1'b1;
        end
        else
        begin
            col_nb = (a_col_reg == '0) ? CW'(GRID_COLS - 1) : a_col_reg - 1'b1;
        end
        if (a_up_reg)
        begin
            row_nb = a_row_reg + 1'b1;
            do_y   = a_row_reg != RW'(GRID_ROWS - 1);
        end
        else
        begin
            row_nb = a_row_reg - 1'b1;
            do_y   = a_row_reg != '0;
        end
    end

    assign p_col = $signed({5'b0, a_lon_reg}) - $signed({1'b0, 13'(col_nb), 16'h8000});

    always_comb
    begin
        if (p_col < -ONE_S)
        begin
            p_wrap = p_col + WRAP;
        end
        else if (p_col > ONE_S)
        begin
            p_wrap = p_col - WRAP;
        end
        else
        begin
            p_wrap = p_col;
        end
    end

    assign q_row = $signed({{6{a_lat_reg[23]}}, a_lat_reg})
                 - $signed({1'b0, 13'(row_nb), 16'h0000}) + ROW_K;

    assign ip0 = gbi_weight(p_wrap);
    assign jp0 = do_y ? gbi_weight(q_row) : ONE_Q16;

    always_comb
    begin
        if (a_oor_reg)
        begin
            entry.kind = KIND_RANGE;
        end
        else if (a_action_reg)
        begin
            entry.kind = KIND_QUERY;
        end
        else
        begin
            entry.kind = KIND_LOAD;
        end
        entry.ip0   = ip0;
        entry.ip1   = ONE_Q16 - ip0;
        entry.jp0   = jp0;
        entry.jp1   = ONE_Q16 - jp0;
        entry.do_y  = do_y;
        entry.value = a_value_reg;
    end

    assign col        = a_col_reg;
    assign row        = a_row_reg;
    assign push_valid = a_valid_reg;

endmodule

// ===== design/gbi_queue.sv =====
module gbi_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_full,
    input  logic [WIDTH-1:0] push_data,
    output logic             head_valid,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data
);
    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_full  = count_reg == (PW+1)'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_data  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && !push_full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PW+1)'(DEPTH))
        else $error("queue count beyond depth");
    a_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (push_full && !do_pop) |=> $stable(wr_ptr_reg))
        else $error("write pointer moved while full");
    a_empty_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |=> $stable(rd_ptr_reg))
        else $error("read pointer moved while empty");
`endif

endmodule

// ===== design/gbi_back.sv =====
module gbi_back #(
    parameter int GRID_COLS = 360,
    parameter int GRID_ROWS = 180,
    localparam int CW = $clog2(GRID_COLS),
    localparam int RW = $clog2(GRID_ROWS),
    localparam int CELLS = GRID_COLS * GRID_ROWS,
    localparam int AW = $clog2(CELLS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  gbi_pkg::entry_t     head,
    input  logic [CW-1:0]       col,
    input  logic [RW-1:0]       row,
    input  logic [CW-1:0]       col_nb,
    input  logic [RW-1:0]       row_nb,
    output logic                pop,
    output logic                result_valid,
    input  logic                result_stall,
    output logic signed [15:0]  interpolated,
    output logic [1:0]          status
);
    import gbi_pkg::*;

    localparam logic signed [51:0] ROUND_HALF = 52'sd2147483648;

    logic [15:0]         grid_mem [CELLS];

    logic [1:0]          k_reg, k_next;
    logic                a_valid_reg, r_valid_reg, m_valid_reg, s_valid_reg, y_valid_reg;
    logic                out_valid_reg;
    op_t                 a_op_reg, r_op_reg, m_op_reg, s_op_reg, y_op_reg;
    logic [AW-1:0]       a_addr_reg;
    logic [15:0]         a_wdata_reg;
    logic [15:0]         rdata_reg;
    logic signed [33:0]  prod_reg;
    logic signed [33:0]  t_reg;
    logic signed [33:0]  tsum_reg;
    logic signed [51:0]  yprod_reg;
    logic signed [51:0]  f_reg;
    logic signed [15:0]  out_value_reg;
    logic [1:0]          out_status_reg;

    logic                adv;
    logic                op_last;
    logic [RW-1:0]       issue_row;
    logic [CW-1:0]       issue_col;
    logic [AW-1:0]       issue_addr;
    op_t                 issue_op;
    logic signed [33:0]  prod_next;
    logic signed [51:0]  yprod_next;
    logic signed [51:0]  sum;
    logic signed [19:0]  res_wide;
    logic signed [15:0]  res_sat;
    logic [1:0]          status_next;

    assign adv     = !(out_valid_reg && result_stall);
    assign op_last = (head.kind != KIND_QUERY) || (k_reg == (head.do_y ? 2'd3 : 2'd1));
    assign pop     = adv && head_valid && op_last;

    assign issue_row  = k_reg[1] ? row_nb : row;
    assign issue_col  = k_reg[0] ? col_nb : col;
    assign issue_addr = AW'(int'(issue_row) * GRID_COLS + int'(issue_col));

    always_comb
    begin
        issue_op.kind    = head.kind;
        issue_op.w       = k_reg[0] ? head.ip1 : head.ip0;
        issue_op.jw      = k_reg[1] ? head.jp1 : head.jp0;
        issue_op.t_end   = k_reg[0] || (head.kind != KIND_QUERY);
        issue_op.y_first = !k_reg[1];
        issue_op.y_last  = op_last;
    end

    always_comb
    begin
        k_next = k_reg;
        if (adv && head_valid)
        begin
            k_next = op_last ? 2'd0 : k_reg + 2'd1;
        end
    end

    assign prod_next  = $signed({1'b0, r_op_reg.w}) * $signed(rdata_reg);
    assign yprod_next = $signed({1'b0, s_op_reg.jw}) * tsum_reg;
    assign sum        = (y_op_reg.y_first ? ROUND_HALF : f_reg) + yprod_reg;
    assign res_wide   = sum[51:32];

    always_comb
    begin
        if (res_wide > 20'sd32767)
        begin
            res_sat = 16'sh7fff;
        end
        else if (res_wide < -20'sd32768)
        begin
            res_sat = -16'sh8000;
        end
        else
        begin
            res_sat = res_wide[15:0];
        end
    end

    always_comb
    begin
        case (y_op_reg.kind)
            KIND_LOAD:  status_next = STATUS_LOADED;
            KIND_RANGE: status_next = STATUS_RANGE;
            default:    status_next = STATUS_OK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= 2'd0;
            a_valid_reg   <= 1'b0;
            r_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            s_valid_reg   <= 1'b0;
            y_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg <= k_next;
            if (adv)
            begin
                a_valid_reg   <= head_valid;
                r_valid_reg   <= a_valid_reg;
                m_valid_reg   <= r_valid_reg;
                s_valid_reg   <= m_valid_reg && m_op_reg.t_end;
                y_valid_reg   <= s_valid_reg;
                out_valid_reg <= y_valid_reg && y_op_reg.y_last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (a_valid_reg && a_op_reg.kind == KIND_LOAD)
            begin
                grid_mem[a_addr_reg] <= a_wdata_reg;
            end
            rdata_reg <= grid_mem[a_addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_op_reg    <= issue_op;
            a_addr_reg  <= issue_addr;
            a_wdata_reg <= head.value;
            r_op_reg    <= a_op_reg;
            m_op_reg    <= r_op_reg;
            prod_reg    <= prod_next;
            if (m_valid_reg && !m_op_reg.t_end)
            begin
                t_reg <= prod_reg;
            end
            s_op_reg  <= m_op_reg;
            tsum_reg  <= t_reg + prod_reg;
            y_op_reg  <= s_op_reg;
            yprod_reg <= yprod_next;
            if (y_valid_reg && !y_op_reg.y_last)
            begin
                f_reg <= sum;
            end
            out_status_reg <= status_next;
            out_value_reg  <= (y_op_reg.kind == KIND_QUERY) ? res_sat : 16'sd0;
        end
    end

    assign result_valid = out_valid_reg;
    assign interpolated = out_value_reg;
    assign status       = out_status_reg;

`ifndef NO_ASSERTIONS
    a_polar_two_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && head.kind == KIND_QUERY && !head.do_y) |-> !k_reg[1])
        else $error("polar query issued a second row");
    a_single_op: assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && head.kind != KIND_QUERY) |-> (k_reg == 2'd0))
        else $error("non-query item in mid sequence");
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_stall) |=> ($stable(k_reg) && $stable(y_valid_reg)))
        else $error("pipeline moved while output held");
    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != STATUS_OK) |-> (out_value_reg == 16'sd0))
        else $error("nonzero value with error status");
`endif

endmodule

// ===== design/grid_bilinear_interpolator_core.sv =====
// Bilinear interpolation over a global grid of signed 16-bit samples.
// Input channel: item_valid/item_stall with action, grid_col, grid_row,
// cell_value, latitude, longitude. A load (action 0) writes one cell; a
// query (action 1) blends the four nearest cells, or two at a polar row.
// Output channel: result_valid/result_stall with interpolated and status
// (0 ok, 1 index out of range, 2 load done). Every item gives one result.
// The single-port grid RAM serves one access per cycle while the output is
// not held, so a query takes one access for each cell it blends; a load or
// range error takes one access. The front end keeps taking items into a 4-entry
// queue while the back end works.
// A query may only read cells that were loaded before; the grid RAM is not
// cleared. Reset empties the pipeline and queue; nothing else is needed.
// While result_stall is high with a result waiting, the back pipeline holds; the front keeps
// accepting until the queue fills, then raises item_stall.
module grid_bilinear_interpolator_core #(
    parameter int GRID_COLS = 360,
    parameter int GRID_ROWS = 180
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic                action,
    input  logic signed [10:0]  grid_col,
    input  logic signed [10:0]  grid_row,
    input  logic signed [15:0]  cell_value,
    input  logic signed [23:0]  latitude,
    input  logic        [24:0]  longitude,
    output logic                result_valid,
    input  logic                result_stall,
    output logic signed [15:0]  interpolated,
    output logic [1:0]          status
);
    import gbi_pkg::*;

    localparam int CW = $clog2(GRID_COLS);
    localparam int RW = $clog2(GRID_ROWS);
    localparam int QW = $bits(entry_t) + 2 * CW + 2 * RW;
    localparam int QUEUE_DEPTH = 4;

    logic          push_valid;
    logic          push_full;
    entry_t        f_entry;
    logic [CW-1:0] f_col, f_col_nb;
    logic [RW-1:0] f_row, f_row_nb;
    logic [QW-1:0] push_data;
    logic [QW-1:0] head_data;
    logic          head_valid;
    logic          pop;
    entry_t        h_entry;
    logic [CW-1:0] h_col, h_col_nb;
    logic [RW-1:0] h_row, h_row_nb;

    gbi_front #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .action     (action),
        .grid_col   (grid_col),
        .grid_row   (grid_row),
        .cell_value (cell_value),
        .latitude   (latitude),
        .longitude  (longitude),
        .push_valid (push_valid),
        .push_full  (push_full),
        .entry      (f_entry),
        .col        (f_col),
        .row        (f_row),
        .col_nb     (f_col_nb),
        .row_nb     (f_row_nb)
    );

    assign push_data = {f_entry, f_col, f_row, f_col_nb, f_row_nb};

    gbi_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_full  (push_full),
        .push_data  (push_data),
        .head_valid (head_valid),
        .pop        (pop),
        .head_data  (head_data)
    );

    assign {h_entry, h_col, h_row, h_col_nb, h_row_nb} = head_data;

    gbi_back #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (h_entry),
        .col          (h_col),
        .row          (h_row),
        .col_nb       (h_col_nb),
        .row_nb       (h_row_nb),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .interpolated (interpolated),
        .status       (status)
    );

endmodule

// ===== verif/grid_bilinear_interpolator_core_test.sv =====
module grid_bilinear_interpolator_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gbi_pkg::*;

    localparam int COLS = 360;
    localparam int ROWS = 180;
    localparam longint ONE = 65536;
    localparam longint HALF = 32768;
    localparam int IDLE_LIMIT = 20000;
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic              action;
        logic signed [10:0] col;
        logic signed [10:0] row;
        logic signed [15:0] value;
        logic signed [23:0] lat;
        logic [24:0]        lon;
    } item_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic [1:0]         code;
    } outcome_t;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    logic action;
    logic signed [10:0] grid_col;
    logic signed [10:0] grid_row;
    logic signed [15:0] cell_value;
    logic signed [23:0] latitude;
    logic [24:0] longitude;
    logic result_valid;
    logic result_stall;
    logic signed [15:0] interpolated;
    logic [1:0] status;

    grid_bilinear_interpolator_core dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall),
        .action(action), .grid_col(grid_col), .grid_row(grid_row),
        .cell_value(cell_value), .latitude(latitude), .longitude(longitude),
        .result_valid(result_valid), .result_stall(result_stall),
        .interpolated(interpolated), .status(status)
    );

    item_t    pending_items[$];
    outcome_t expected_outcomes[$];
    logic signed [15:0] grid_model[ROWS*COLS];
    int       error_count;
    int       idle_cycles;
    int       queries_done;
    int       loads_done;
    int       ranges_done;
    int       burst_left;
    int       gap_left;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic longint clamp_weight(input longint p);
        longint a;
        a = p < 0 ? -p : p;
        return a > ONE ? ONE : a;
    endfunction

    function automatic longint round_to_sample(input longint v, input int sh);
        longint r;
        v = v + (longint'(1) <<< (sh - 1));
        r = v >>> sh;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r;
    endfunction

    function automatic longint grid_at(input longint r, input longint c);
        return longint'(grid_model[r*COLS + c]);
    endfunction

    function automatic outcome_t interpolate_item(input item_t it);
        outcome_t o;
        longint i, j, lat, lon, i1, j1, p, ip0, ip1, jp0, jp1, t0, t1, s;
        bit use_rows;
        o.sample = '0;
        i = it.col;
        j = it.row;
        lat = it.lat;
        lon = it.lon;
        use_rows = 1'b1;
        if (j < 0 || j > ROWS - 1 || i < 0 || i > COLS - 1)
        begin
            o.code = STATUS_RANGE;
            return o;
        end
        if (it.action == ACT_LOAD)
        begin
            grid_model[j*COLS + i] = it.value;
            o.code = STATUS_LOADED;
            return o;
        end
        if (lon - i*ONE >= HALF)
            i1 = (i == COLS - 1) ? 0 : i + 1;
        else
            i1 = (i == 0) ? COLS - 1 : i - 1;
        if (lat - (j - ROWS/2)*ONE >= HALF)
        begin
            j1 = j + 1;
            if (j == ROWS - 1)
                use_rows = 1'b0;
        end
        else
        begin
            j1 = j - 1;
            if (j == 0)
                use_rows = 1'b0;
        end
        p = lon - (i1*ONE + HALF);
        if (p < -ONE)
            p += COLS*ONE;
        if (p > ONE)
            p -= COLS*ONE;
        ip0 = clamp_weight(p);
        ip1 = ONE - ip0;
        t0 = ip0*grid_at(j, i) + ip1*grid_at(j, i1);
        if (use_rows)
        begin
            p = lat - ((j1 - ROWS/2)*ONE + HALF);
            jp0 = clamp_weight(p);
            jp1 = ONE - jp0;
            t1 = ip0*grid_at(j1, i) + ip1*grid_at(j1, i1);
            s = round_to_sample(jp0*t0 + jp1*t1, 32);
        end
        else
            s = round_to_sample(t0, 16);
        o.sample = s[15:0];
        o.code = STATUS_OK;
        return o;
    endfunction

    // shadow of the grid as the stimulus is built; queries only touch loaded cells
    bit built_loaded[ROWS*COLS];

    function automatic item_t make_load(input int c, input int r, input int v);
        item_t it;
        it = '0;
        it.action = ACT_LOAD;
        it.col = 11'(c);
        it.row = 11'(r);
        it.value = 16'(v);
        it.lat = 24'($urandom);
        it.lon = 25'($urandom);
        if (c >= 0 && c < COLS && r >= 0 && r < ROWS)
            built_loaded[r*COLS + c] = 1'b1;
        return it;
    endfunction

    function automatic item_t make_query(input int c, input int r,
                                         input longint la, input longint lo);
        item_t it;
        it = '0;
        it.action = ACT_QUERY;
        it.col = 11'(c);
        it.row = 11'(r);
        it.value = 16'($urandom);
        it.lat = 24'(la);
        it.lon = 25'(lo);
        return it;
    endfunction

    // load the block of neighbors around (c, r) so any query there is legal
    task automatic load_around(input int c, input int r, input bit extreme);
        int dc, dr, cc, rr, v;
        for (dr = -1; dr <= 1; dr++)
            for (dc = -1; dc <= 1; dc++)
            begin
                cc = (c + dc + COLS) % COLS;
                rr = r + dr;
                if (rr < 0 || rr >= ROWS)
                    continue;
                if (extreme)
                    v = ($urandom_range(1) != 0) ? 32767 : -32768;
                else
                    v = $urandom_range(65535) - 32768;
                pending_items.push_back(make_load(cc, rr, v));
            end
    endtask

    function automatic longint pick_lat(input int r);
        longint centre;
        centre = (longint'(r) - ROWS/2)*ONE + HALF;
        case ($urandom_range(5))
            0: return -5898240;
            1: return 5898240;
            2: return centre + $urandom_range(2*ONE) - ONE;
            default: return centre + $urandom_range(ONE) - HALF;
        endcase
    endfunction

    function automatic longint pick_lon(input int c);
        longint centre, v;
        centre = longint'(c)*ONE + HALF;
        case ($urandom_range(5))
            0: return 0;
            1: return 23592960;
            2: return $urandom_range(33554431);
            default:
            begin
                v = centre + $urandom_range(ONE) - HALF;
                if (v < 0)
                    v = 0;
                return v;
            end
        endcase
    endfunction

    function automatic bit query_ok(input item_t it);
        int i, j, i1, j1;
        longint lat, lon;
        i = it.col;
        j = it.row;
        lat = it.lat;
        lon = it.lon;
        if (i < 0 || i >= COLS || j < 0 || j >= ROWS)
            return 1'b1;
        if (lon - longint'(i)*ONE >= HALF)
            i1 = (i == COLS - 1) ? 0 : i + 1;
        else
            i1 = (i == 0) ? COLS - 1 : i - 1;
        if (lat - (longint'(j) - ROWS/2)*ONE >= HALF)
            j1 = (j == ROWS - 1) ? j : j + 1;
        else
            j1 = (j == 0) ? j : j - 1;
        return built_loaded[j*COLS + i] && built_loaded[j*COLS + i1] &&
               built_loaded[j1*COLS + i] && built_loaded[j1*COLS + i1];
    endfunction

    task automatic add_query(input int c, input int r, input longint la, input longint lo);
        item_t q;
        q = make_query(c, r, la, lo);
        if (query_ok(q))
            pending_items.push_back(q);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            action <= 1'b0;
            grid_col <= '0;
            grid_row <= '0;
            cell_value <= '0;
            latitude <= '0;
            longitude <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (!(item_valid && item_stall))
        begin
            if (item_valid)
                expected_outcomes.push_back(interpolate_item({action, grid_col, grid_row,
                                                              cell_value, latitude,
                                                              longitude}));
            if (pending_items.size() != 0 && gap_left == 0)
            begin
                item_t it;
                it = pending_items.pop_front();
                item_valid <= 1'b1;
                {action, grid_col, grid_row, cell_value, latitude, longitude} <= it;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(30, 1);
                    gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(8);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
            begin
                item_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_outcomes.size() == 0)
                    report_mismatch("unexpected result status", status, -1);
                else
                begin
                    outcome_t e;
                    e = expected_outcomes.pop_front();
                    if (status !== e.code)
                        report_mismatch("status", status, e.code);
                    if (interpolated !== e.sample)
                        report_mismatch("interpolated", interpolated, e.sample);
                    case (e.code)
                        STATUS_OK: queries_done++;
                        STATUS_LOADED: loads_done++;
                        default: ranges_done++;
                    endcase
                end
            end
            case (($urandom_range(2000) / 500) % 4)
                0: result_stall <= 1'b0;
                1: result_stall <= ($urandom_range(3) == 0);
                2: result_stall <= ($urandom_range(1) == 0);
                default: result_stall <= ($urandom_range(9) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no handshake in %0d cycles", IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int n, c, r, k;
        error_count = 0;
        queries_done = 0;
        loads_done = 0;
        ranges_done = 0;
        rst_n = 1'b0;
        pending_items.delete();

        // corners, poles, wrap columns with extreme samples
        load_around(0, 0, 1'b1);
        load_around(COLS - 1, ROWS - 1, 1'b1);
        add_query(0, 0, -5898240, 0);
        add_query(0, 0, -5898240 + ONE, HALF + 100);
        add_query(COLS - 1, ROWS - 1, 5898240, 23592960);
        add_query(COLS - 1, ROWS - 1, 5898240 - ONE - 10, 23592960 - HALF - 5);
        add_query(0, 1, -89*ONE + HALF, 0);
        add_query(COLS - 1, ROWS - 2, 89*ONE - 1, 23592960);
        add_query(0, 0, 5898240, 23592960);
        add_query(0, 0, -5898240, 33554431);
        pending_items.push_back(make_query(-1024, 5, 0, 0));
        pending_items.push_back(make_query(5, 1023, 0, 0));
        pending_items.push_back(make_query(COLS, 0, 0, 0));
        pending_items.push_back(make_query(0, ROWS, 0, 0));
        pending_items.push_back(make_load(-1, 3, 123));
        pending_items.push_back(make_load(3, -1024, -1));
        pending_items.push_back(make_load(1023, 1023, 32767));

        n = 0;
        while (n < 1700)
        begin
            k = $urandom_range(9);
            if (k < 7)
            begin
                c = $urandom_range(COLS - 1);
                r = ($urandom_range(7) == 0) ? (($urandom_range(1) != 0) ? ROWS - 1 : 0)
                                             : $urandom_range(ROWS - 1);
                load_around(c, r, $urandom_range(7) == 0);
                n += 9;
                repeat ($urandom_range(5, 1))
                begin
                    add_query(c, r, pick_lat(r), pick_lon(c));
                    n++;
                end
            end
            else if (k == 7)
            begin
                add_query($urandom_range(2047) - 1024, $urandom_range(2047) - 1024,
                          $urandom, $urandom);
                n++;
            end
            else if (k == 8)
            begin
                pending_items.push_back(make_load($urandom_range(2047) - 1024,
                                                  $urandom_range(2047) - 1024,
                                                  $urandom_range(65535) - 32768));
                n++;
            end
            else
            begin
                // query against any already loaded neighborhood
                c = $urandom_range(COLS - 1);
                r = $urandom_range(ROWS - 1);
                add_query(c, r, pick_lat(r), pick_lon(c));
                n++;
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_items.size() == 0);
        @(posedge clk);
        while (item_valid || expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("covered %0d queries, %0d loads, %0d range errors",
                 queries_done, loads_done, ranges_done);
        if (error_count == 0 && expected_outcomes.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
design/gbi_pkg.sv
design/gbi_front.sv
design/gbi_queue.sv
design/gbi_back.sv
design/grid_bilinear_interpolator_core.sv
verif/grid_bilinear_interpolator_core_test.sv
